FILE: hdl/assert_macros.svh
// Assertion macros shared by the RTL modules of the prime test unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skipped while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/tdpt_pkg.sv
// Package with shared constants and controller/datapath interface types.
package tdpt_pkg;

	// Default width of the tested value
	localparam int VALUE_BITS_DEF = 32;

	// First trial divisor
	localparam int DIVISOR_FIRST = 2;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;      // capture magnitude, restart at the first divisor
		logic div_init;  // start a remainder computation
		logic div_step;  // one restoring-division step
		logic advance;   // move on to the next divisor
	} tdpt_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic mag_lt2;   // magnitude is 0 or 1
		logic sq_gt_m;   // divisor squared exceeds the magnitude
		logic div_last;  // current division step is the final one
		logic rem_zero;  // remainder of the finished division is zero
	} tdpt_status_t;

endpackage

FILE: hdl/trial_division_prime_test_unit.sv
// Top level of the trial-division prime test unit.
// Tests whether |value| is prime; 0 and 1 report not prime, and the most
// negative value is taken as 2^(VALUE_BITS-1). Pulse start while busy is low to
// begin a transaction; the result appears on is_prime with done high for exactly
// one cycle and cannot be held off by the receiver. Each trial divisor d = 2, 3,
// ... passes through a shared one-bit-per-cycle restoring remainder unit plus
// a square check and an advance step, and the test stops at the first divisor
// that divides or once d*d exceeds the magnitude. busy falls on the edge that
// raises done, so the next transaction can be accepted while the result is on
// the ports.

module trial_division_prime_test_unit
	import tdpt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [VALUE_BITS-1:0] value,
	output logic                         busy,
	output logic                         done,
	output logic                         is_prime
);

	tdpt_cmd_t    cmd;
	tdpt_status_t status;

	// Sequencer
	tdpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done),
		.is_prime (is_prime)
	);

	// Arithmetic
	tdpt_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.value  (value),
		.cmd    (cmd),
		.status (status)
	);

endmodule

FILE: hdl/tdpt_dp.sv
// Datapath: magnitude, divisor, running square and bit-serial remainder unit.
`include "assert_macros.svh"

module tdpt_dp
	import tdpt_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [VALUE_BITS-1:0] value,
	input  tdpt_cmd_t                    cmd,
	output tdpt_status_t                 status
);

	localparam int DBITS = VALUE_BITS / 2 + 1;   // divisor width
	localparam int SQW   = VALUE_BITS + 1;       // divisor square width
	localparam int CW    = $clog2(VALUE_BITS);   // division step counter width

	logic [VALUE_BITS-1:0] mag_q;
	logic [VALUE_BITS-1:0] sh_q;
	logic [DBITS-1:0]      d_q;
	logic [DBITS-1:0]      rem_q;
	logic [SQW-1:0]        sq_q;
	logic [CW-1:0]         cnt_q;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag_n;
	logic [DBITS:0]        trial;
	logic                  trial_ge;
	logic [DBITS-1:0]      rem_n;

	// Two's complement magnitude; the most negative value maps to 2^(N-1)
	assign raw   = value;
	assign mag_n = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

	// Restoring division step: shift in the next magnitude bit, subtract if it fits
	assign trial    = {rem_q, sh_q[VALUE_BITS-1]};
	assign trial_ge = trial >= {1'b0, d_q};
	assign rem_n    = trial_ge ? DBITS'(trial - {1'b0, d_q}) : DBITS'(trial);

	// Datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			sh_q  <= '0;
			d_q   <= DBITS'(DIVISOR_FIRST);
			rem_q <= '0;
			sq_q  <= SQW'(DIVISOR_FIRST * DIVISOR_FIRST);
			cnt_q <= '0;
		end else begin
			if (cmd.load) begin
				mag_q <= mag_n;
				d_q   <= DBITS'(DIVISOR_FIRST);
				sq_q  <= SQW'(DIVISOR_FIRST * DIVISOR_FIRST);
				rem_q <= '0;
			end
			if (cmd.div_init) begin
				sh_q  <= mag_q;
				rem_q <= '0;
				cnt_q <= CW'(VALUE_BITS - 1);
			end
			if (cmd.div_step) begin
				sh_q  <= sh_q << 1;
				rem_q <= rem_n;
				cnt_q <= cnt_q - 1'b1;
			end
			// (d+1)^2 = d^2 + 2d + 1
			if (cmd.advance) begin
				d_q  <= d_q + 1'b1;
				sq_q <= sq_q + SQW'({d_q, 1'b1});
			end
		end
	end

	// Status toward the controller
	assign status.mag_lt2  = mag_q < VALUE_BITS'(DIVISOR_FIRST);
	assign status.sq_gt_m  = sq_q > {1'b0, mag_q};
	assign status.div_last = cnt_q == '0;
	assign status.rem_zero = rem_q == '0;

	// The partial remainder always stays below the divisor
	`ASSERT_CLK(a_rem_below_div, rem_q < d_q, "partial remainder reached the divisor")
	// The divisor never drops below the first trial divisor
	`ASSERT_NEVER(a_div_floor, d_q < DBITS'(DIVISOR_FIRST), "divisor below first trial value")

endmodule

FILE: hdl/tdpt_ctrl.sv
// Controller: sequences load, trial divisions and result reporting.
`include "assert_macros.svh"

module tdpt_ctrl
	import tdpt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  tdpt_status_t status,
	output tdpt_cmd_t    cmd,
	output logic         busy,
	output logic         done,
	output logic         is_prime
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_CHECK = 4'b0010,
		S_DIV   = 4'b0100,
		S_TEST  = 4'b1000
	} state_t;

	state_t state_q, state_n;
	logic   done_q, done_n;
	logic   prime_q, prime_n;

	// Next state and command decode
	always_comb begin
		state_n = state_q;
		cmd     = '0;
		done_n  = 1'b0;
		prime_n = prime_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_n  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (status.mag_lt2) begin
					done_n  = 1'b1;
					prime_n = 1'b0;
					state_n = S_IDLE;
				end else if (status.sq_gt_m) begin
					// no divisor up to the square root divided the magnitude
					done_n  = 1'b1;
					prime_n = 1'b1;
					state_n = S_IDLE;
				end else begin
					cmd.div_init = 1'b1;
					state_n      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_n = S_TEST;
				end
			end
			S_TEST: begin
				if (status.rem_zero) begin
					done_n  = 1'b1;
					prime_n = 1'b0;
					state_n = S_IDLE;
				end else begin
					cmd.advance = 1'b1;
					state_n     = S_CHECK;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	// State and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			prime_q <= 1'b0;
		end else begin
			state_q <= state_n;
			done_q  <= done_n;
			prime_q <= prime_n;
		end
	end

	assign busy     = state_q != S_IDLE;
	assign done     = done_q;
	assign is_prime = prime_q;

	// Result strobe lasts one cycle
	`ASSERT_CLK(a_done_pulse, done |=> !done, "result strobe held longer than one cycle")
	// A started transaction makes the unit busy
	`ASSERT_CLK(a_start_busy, (start && !busy) |=> busy, "accepted transaction did not go busy")
	// A result is only reported once the unit is back to idle
	`ASSERT_CLK(a_done_idle, done |-> !busy, "result strobe while still busy")

endmodule
